[hdl/grayscale_dilate_3x3_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grayscale 3x3 dilation block
// Concurrent property helpers used by the checks in the top-level module.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_DILATE_3X3_TOP_ASSERT_SVH
`define GRAYSCALE_DILATE_3X3_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GD3_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define GD3_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[hdl/gd3_pkg.sv]
// ----------------------------------------------------------------------------
// gd3_pkg
// Shared widths, register codes and inter-module types of the 3x3 dilation.
// ----------------------------------------------------------------------------
package gd3_pkg;

   // Frame limits and field widths.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 11;
   localparam int CFG_W      = 12;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int WIN_N      = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from the word address.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Effective frame size after clamping of the registers.
   typedef struct packed {
      logic [CFG_W-1:0]   w_eff;
      logic [CFG_W-1:0]   h_eff;
      logic [COORD_W-1:0] w_last;
      logic [COORD_W-1:0] h_last;
   } cfg_type;

   // One input's worth of result work: the updated window and where it sits.
   typedef struct packed {
      logic [WIN_N-1:0][PIX_W-1:0] win;
      logic [COORD_W-1:0]          col;
      logic [COORD_W-1:0]          row;
      logic                        y_a;
      logic                        y_b;
      logic                        x_a;
      logic                        x_b;
      logic                        row_ge2;
      logic                        col_ge2;
   } job_type;

endpackage

[hdl/gd3_csr.sv]
// ----------------------------------------------------------------------------
// gd3_csr
// Width and height registers behind the APB-style port, with size clamping.
// ----------------------------------------------------------------------------
module gd3_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gd3_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gd3_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gd3_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output gd3_pkg::cfg_type               cfg
);
   import gd3_pkg::*;

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] width_in;
   logic [CFG_W-1:0] height_ff;
   logic [CFG_W-1:0] height_in;
   logic             wr_beat;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // Register write decode.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_beat) begin
         unique case (reg_sel)
            REG_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(640);
         height_ff <= CFG_W'(480);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Read back the raw register values.
   always_comb begin
      unique case (reg_sel)
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // A zero size acts as one and an oversize value as the maximum.
   always_comb begin
      if (width_ff == '0) begin
         cfg.w_eff = CFG_W'(1);
      end else if (width_ff > CFG_W'(MAX_WIDTH)) begin
         cfg.w_eff = CFG_W'(MAX_WIDTH);
      end else begin
         cfg.w_eff = width_ff;
      end
      if (height_ff == '0) begin
         cfg.h_eff = CFG_W'(1);
      end else if (height_ff > CFG_W'(MAX_HEIGHT)) begin
         cfg.h_eff = CFG_W'(MAX_HEIGHT);
      end else begin
         cfg.h_eff = height_ff;
      end
      cfg.w_last = COORD_W'(cfg.w_eff - 1'b1);
      cfg.h_last = COORD_W'(cfg.h_eff - 1'b1);
   end

endmodule

[hdl/gd3_line_buf.sv]
// ----------------------------------------------------------------------------
// gd3_line_buf
// Position counters, the two-row line memory and the 3x3 pixel window.
// ----------------------------------------------------------------------------
module gd3_line_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  gd3_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [gd3_pkg::PIX_W-1:0] req_pixel_in,
   input  logic                      job_free,
   output logic                      job_push,
   output gd3_pkg::job_type          job
);
   import gd3_pkg::*;

   logic [COORD_W-1:0]          col_ff;
   logic [COORD_W-1:0]          col_in;
   logic [COORD_W-1:0]          row_ff;
   logic [COORD_W-1:0]          row_in;
   logic [COORD_W-1:0]          col_cur;
   logic [COORD_W-1:0]          row_cur;
   logic                        accept;
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic                        s1_adv;
   logic [PIX_W-1:0]            s1_pix_ff;
   logic [COORD_W-1:0]          s1_col_ff;
   logic [COORD_W-1:0]          s1_row_ff;
   logic [2*PIX_W-1:0]          line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0]          rd_q_ff;
   logic                        fwd_ff;
   logic [2*PIX_W-1:0]          fwd_data_ff;
   logic [2*PIX_W-1:0]          line_pair;
   logic [2*PIX_W-1:0]          write_pair;
   logic [PIX_W-1:0]            top_pix;
   logic [PIX_W-1:0]            mid_pix;
   logic [WIN_N-1:0][PIX_W-1:0] win_ff;
   logic [WIN_N-1:0][PIX_W-1:0] win_in;
   logic [WIN_N-1:0][PIX_W-1:0] win_shift;
   logic                        has_results;

   // Counters left beyond a smaller frame size restart at zero.
   assign col_cur = ({1'b0, col_ff} >= cfg.w_eff) ? '0 : col_ff;
   assign row_cur = ({1'b0, row_ff} >= cfg.h_eff) ? '0 : row_ff;

   // Stage one moves on unless it has results and the sequencer is busy.
   assign has_results = (job.y_a || job.y_b) && (job.x_a || job.x_b);
   assign s1_adv      = s1_valid_ff && (job_free || !has_results);
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign accept      = req_valid && req_ready;
   assign job_push    = s1_adv && has_results;

   // Raster position of the next beat.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_cur == cfg.w_last) begin
            col_in = '0;
            row_in = (row_cur == cfg.h_last) ? '0 : COORD_W'(row_cur + 1'b1);
         end else begin
            col_in = COORD_W'(col_cur + 1'b1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Line pair read back; the write of the item ahead is forwarded when the
   // same column was read in the cycle it was written (one-pixel rows).
   assign line_pair  = fwd_ff ? fwd_data_ff : rd_q_ff;
   assign top_pix    = line_pair[2*PIX_W-1:PIX_W];
   assign mid_pix    = line_pair[PIX_W-1:0];
   assign write_pair = {mid_pix, s1_pix_ff};

   // Window shifts one column left and takes the new column on the right.
   always_comb begin
      win_shift = win_ff;
      for (int i = 0; i < 3; i++) begin
         win_shift[i*3]     = win_ff[i*3 + 1];
         win_shift[i*3 + 1] = win_ff[i*3 + 2];
      end
      win_shift[2] = top_pix;
      win_shift[5] = mid_pix;
      win_shift[8] = s1_pix_ff;
      win_in = s1_adv ? win_shift : win_ff;
   end

   // Result work for the sequencer, taken from the updated window.
   always_comb begin
      job.win     = win_shift;
      job.col     = s1_col_ff;
      job.row     = s1_row_ff;
      job.y_a     = (s1_row_ff != '0);
      job.y_b     = (s1_row_ff == cfg.h_last);
      job.x_a     = (s1_col_ff != '0);
      job.x_b     = (s1_col_ff == cfg.w_last);
      job.row_ge2 = (s1_row_ff[COORD_W-1:1] != '0);
      job.col_ge2 = (s1_col_ff[COORD_W-1:1] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         win_ff      <= win_in;
      end
   end

   // Line memory: older row in the upper byte, newer row in the lower byte.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_col_ff[ADDR_W-1:0]] <= write_pair;
      end
      if (accept) begin
         rd_q_ff <= line_mem[col_cur[ADDR_W-1:0]];
      end
   end

   // Stage one payload and the forwarding capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_pixel_in;
         s1_col_ff   <= col_cur;
         s1_row_ff   <= row_cur;
         fwd_ff      <= s1_adv && (s1_col_ff == col_cur);
         fwd_data_ff <= write_pair;
      end
   end

endmodule

[hdl/gd3_result_seq.sv]
// ----------------------------------------------------------------------------
// gd3_result_seq
// Walks the zero to four results of one input and feeds the output register.
// ----------------------------------------------------------------------------
module gd3_result_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_push,
   input  gd3_pkg::job_type            job,
   output logic                        job_free,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gd3_pkg::PIX_W-1:0]   rsp_dilated_value,
   output logic [gd3_pkg::COORD_W-1:0] rsp_out_col,
   output logic [gd3_pkg::COORD_W-1:0] rsp_out_row,
   output logic                        rsp_last_of_run,
   output logic                        rsp_frame_done
);
   import gd3_pkg::*;

   job_type                     job_ff;
   logic                        job_valid_ff;
   logic                        job_valid_in;
   logic                        ysel_ff;
   logic                        ysel_in;
   logic                        xsel_ff;
   logic                        xsel_in;
   logic                        out_free;
   logic                        emit;
   logic                        next_x;
   logic                        next_y;
   logic                        last;
   logic [2:0]                  row_mask;
   logic [2:0]                  col_mask;
   logic [WIN_N-1:0][PIX_W-1:0] masked;
   logic [2:0][PIX_W-1:0]       row_max;
   logic [PIX_W-1:0]            best;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [PIX_W-1:0]            value_ff;
   logic [COORD_W-1:0]          col_ff;
   logic [COORD_W-1:0]          row_ff;
   logic                        last_ff;
   logic                        done_ff;

   function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // Selection bits: clear picks the earlier coordinate, set the current one.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = job_valid_ff && out_free;
   assign next_x   = !xsel_ff && job_ff.x_b;
   assign next_y   = !ysel_ff && job_ff.y_b;
   assign last     = !next_x && !next_y;
   assign job_free = !job_valid_ff || (emit && last);

   always_comb begin
      job_valid_in = job_valid_ff;
      ysel_in      = ysel_ff;
      xsel_in      = xsel_ff;
      if (job_push) begin
         job_valid_in = 1'b1;
         ysel_in      = !job.y_a;
         xsel_in      = !job.x_a;
      end else if (emit) begin
         if (last) begin
            job_valid_in = 1'b0;
         end else if (next_x) begin
            xsel_in = 1'b1;
         end else begin
            ysel_in = 1'b1;
            xsel_in = !job_ff.x_a;
         end
      end
   end

   // Window rows and columns that the clamped neighborhood covers.
   always_comb begin
      if (ysel_ff) begin
         row_mask = {1'b1, job_ff.y_a, 1'b0};
      end else begin
         row_mask = {1'b1, 1'b1, job_ff.row_ge2};
      end
      if (xsel_ff) begin
         col_mask = {1'b1, job_ff.x_a, 1'b0};
      end else begin
         col_mask = {1'b1, 1'b1, job_ff.col_ge2};
      end
   end

   // Masked maximum, row by row and then across rows.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            masked[i*3 + j] = (row_mask[i] && col_mask[j]) ? job_ff.win[i*3 + j] : '0;
         end
      end
      for (int i = 0; i < 3; i++) begin
         row_max[i] = max3(masked[i*3], masked[i*3 + 1], masked[i*3 + 2]);
      end
      best = max3(row_max[0], row_max[1], row_max[2]);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Job payload and selection state.
   always_ff @(posedge clock) begin
      if (job_push) begin
         job_ff <= job;
      end
      ysel_ff <= ysel_in;
      xsel_ff <= xsel_in;
   end

   // Output register; a set selection on both axes is the frame corner.
   always_ff @(posedge clock) begin
      if (emit) begin
         value_ff <= best;
         col_ff   <= xsel_ff ? job_ff.col : COORD_W'(job_ff.col - 1'b1);
         row_ff   <= ysel_ff ? job_ff.row : COORD_W'(job_ff.row - 1'b1);
         last_ff  <= last;
         done_ff  <= xsel_ff && ysel_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dilated_value = value_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_frame_done    = done_ff;

endmodule

[hdl/grayscale_dilate_3x3_top.sv]
// The first result of a beat passes the stage-one, job and output registers.
// Throughput: one pixel per cycle while each pixel yields at most one result and
// the output is not stalled; a pixel that yields several results (up to four at row
// and frame ends) holds the result sequencer and the input until its last is emitted.
// Reset: synchronous; counters, window and control clear, sizes go to 640 x 480,
// and the line memory is left undefined with no clearing pass.
// ----------------------------------------------------------------------------
// grayscale_dilate_3x3_top
// Streaming 3x3 grayscale dilation with edge replication over a raster frame.
// ----------------------------------------------------------------------------
`include "grayscale_dilate_3x3_top_assert.svh"

module grayscale_dilate_3x3_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gd3_pkg::PIX_W-1:0]      req_pixel_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gd3_pkg::PIX_W-1:0]      rsp_dilated_value,
   output logic [gd3_pkg::COORD_W-1:0]    rsp_out_col,
   output logic [gd3_pkg::COORD_W-1:0]    rsp_out_row,
   output logic                           rsp_last_of_run,
   output logic                           rsp_frame_done,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gd3_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gd3_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gd3_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import gd3_pkg::*;

   cfg_type cfg;
   job_type job;
   logic    job_push;
   logic    job_free;

   // Configuration registers.
   gd3_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Line memory, counters and window.
   gd3_line_buf u_line_buf (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel_in (req_pixel_in),
      .job_free     (job_free),
      .job_push     (job_push),
      .job          (job)
   );

   // Result sequencer and output register.
   gd3_result_seq u_result_seq (
      .clock             (clock),
      .reset             (reset),
      .job_push          (job_push),
      .job               (job),
      .job_free          (job_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dilated_value (rsp_dilated_value),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_frame_done    (rsp_frame_done)
   );

   // A new job is only handed over when the sequencer can take it.
   `GD3_ASSERT_IMPLY(a_job_push_free, clock, reset, job_push, job_free,
                     "job pushed into busy sequencer")

   // The frame corner closes the run of the beat that caused it.
   `GD3_ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_valid && rsp_frame_done,
                     rsp_last_of_run, "frame end without end of run")

   // Results of one run follow each other without a gap.
   `GD3_ASSERT_NEXT(a_run_no_gap, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run,
                    rsp_valid, "gap inside a result run")

endmodule

[tb/grayscale_dilate_3x3_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grayscale_dilate_3x3_top_tb
// Self-checking bench for the streaming 3x3 grayscale dilation. A behavioral
// line-store model predicts every dilated pixel, with its coordinates and
// flags, as each input beat is accepted. The results are compared in order.
// Sizes are changed through the register port between bursts, including
// shrinks in the middle of a frame and register values above the maximum.
// ----------------------------------------------------------------------------
module grayscale_dilate_3x3_top_tb;
   import gd3_pkg::*;

   // Register byte addresses, derived from the register indexes.
   localparam bit [CSR_ADDR_W-1:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
   localparam bit [CSR_ADDR_W-1:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};
   localparam int IDLE_PCT    = 28;
   localparam int SETTLE_CYC  = 6;
   localparam int RANDOM_PIX  = 100;
   localparam int MAX_PIX     = 32;

   // One predicted output pixel.
   typedef struct {
      bit [PIX_W-1:0]   value;
      bit [COORD_W-1:0] col;
      bit [COORD_W-1:0] row;
      bit               last;
      bit               done;
   } dilated_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_dilated_value;
   logic [COORD_W-1:0]    rsp_out_col;
   logic [COORD_W-1:0]    rsp_out_row;
   logic                  rsp_last_of_run;
   logic                  rsp_frame_done;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Model state: two line stores, the 3x3 window and the raster position.
   bit [PIX_W-1:0] older_line [MAX_WIDTH];
   bit [PIX_W-1:0] newer_line [MAX_WIDTH];
   bit [PIX_W-1:0] window_px [9];
   int unsigned    col_pos = 0;
   int unsigned    row_pos = 0;
   bit [CFG_W-1:0] size_w = 12'd640;
   bit [CFG_W-1:0] size_h = 12'd480;

   dilated_pixel_type expected_dilations[$];
   int unsigned       mismatch_count = 0;
   bit                steady = 1'b0;

   grayscale_dilate_3x3_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dilated_value (rsp_dilated_value),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_frame_done    (rsp_frame_done),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Zero and oversize register values are clamped to the legal range.
   function automatic int unsigned clamp_size(bit [CFG_W-1:0] v, int unsigned limit);
      if (v == '0) return 1;
      if (v > limit) return limit;
      return 32'(v);
   endfunction

   // Window column (or row) that holds coordinate k when the newest is cur.
   function automatic int unsigned window_slot(int unsigned cur, int unsigned k);
      int unsigned d;
      d = cur - k;
      if (d > 2) d = 2;
      return 2 - d;
   endfunction

   // Maximum over the edge-clamped neighborhood of (x, y).
   function automatic bit [PIX_W-1:0] neighborhood_max(int unsigned x, int unsigned y,
                                                       int unsigned c, int unsigned r,
                                                       int unsigned w, int unsigned h);
      int unsigned    rsel [3];
      int unsigned    csel [3];
      bit [PIX_W-1:0] best;
      rsel[0] = window_slot(r, (y > 0) ? y - 1 : 0);
      rsel[1] = window_slot(r, y);
      rsel[2] = window_slot(r, (y + 1 < h) ? y + 1 : h - 1);
      csel[0] = window_slot(c, (x > 0) ? x - 1 : 0);
      csel[1] = window_slot(c, x);
      csel[2] = window_slot(c, (x + 1 < w) ? x + 1 : w - 1);
      best = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (window_px[rsel[i] * 3 + csel[j]] > best) best = window_px[rsel[i] * 3 + csel[j]];
         end
      end
      return best;
   endfunction

   // Advance the model by one accepted pixel and queue the outputs it completes.
   function automatic void dilate_pixel(bit [PIX_W-1:0] pix);
      int unsigned       w;
      int unsigned       h;
      int unsigned       c;
      int unsigned       r;
      int unsigned       ny;
      int unsigned       nx;
      int unsigned       ys [2];
      int unsigned       xs [2];
      bit [PIX_W-1:0]    top;
      bit [PIX_W-1:0]    mid;
      dilated_pixel_type res;
      w = clamp_size(size_w, MAX_WIDTH);
      h = clamp_size(size_h, MAX_HEIGHT);
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;

      // Line stores shift down by one row at this column.
      top = older_line[c];
      mid = newer_line[c];
      older_line[c] = mid;
      newer_line[c] = pix;
      for (int i = 0; i < 3; i++) begin
         window_px[i * 3]     = window_px[i * 3 + 1];
         window_px[i * 3 + 1] = window_px[i * 3 + 2];
      end
      window_px[2] = top;
      window_px[5] = mid;
      window_px[8] = pix;

      // Outputs whose clamped window is now complete, row-major.
      ny = 0;
      nx = 0;
      if (r >= 1) begin
         ys[ny] = r - 1;
         ny++;
      end
      if (r == h - 1) begin
         ys[ny] = r;
         ny++;
      end
      if (c >= 1) begin
         xs[nx] = c - 1;
         nx++;
      end
      if (c == w - 1) begin
         xs[nx] = c;
         nx++;
      end
      for (int i = 0; i < ny; i++) begin
         for (int j = 0; j < nx; j++) begin
            res.value = neighborhood_max(xs[j], ys[i], c, r, w, h);
            res.col   = COORD_W'(xs[j]);
            res.row   = COORD_W'(ys[i]);
            res.last  = (i + 1 == ny) && (j + 1 == nx);
            res.done  = (xs[j] == w - 1) && (ys[i] == h - 1);
            expected_dilations.push_back(res);
         end
      end

      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic void note_mismatch(string text);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", text);
   endfunction

   function automatic void compare_field(string what, logic [15:0] got, logic [15:0] want,
                                         bit [COORD_W-1:0] col, bit [COORD_W-1:0] row);
      if (got !== want) begin
         note_mismatch($sformatf("%s at col %0d row %0d: expected %0d, got %0d",
                                 what, col, row, want, got));
      end
   endfunction

   // Pixels: a quarter of them at the intensity extremes.
   function automatic bit [PIX_W-1:0] random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // Result sink: random backpressure unless a steady stretch is running.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Every accepted result beat is checked against the oldest prediction.
   always @(posedge clock) begin : compare_dilations
      dilated_pixel_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_dilations.size() == 0) begin
            note_mismatch($sformatf("unexpected result at col %0d row %0d",
                                    rsp_out_col, rsp_out_row));
         end else begin
            want = expected_dilations.pop_front();
            compare_field("dilated_value", 16'(rsp_dilated_value), 16'(want.value),
                          want.col, want.row);
            compare_field("out_col", 16'(rsp_out_col), 16'(want.col), want.col, want.row);
            compare_field("out_row", 16'(rsp_out_row), 16'(want.row), want.col, want.row);
            compare_field("last_of_run", 16'(rsp_last_of_run), 16'(want.last),
                          want.col, want.row);
            compare_field("frame_done", 16'(rsp_frame_done), 16'(want.done),
                          want.col, want.row);
         end
      end
   end

   // Presents one pixel beat, with random idle cycles ahead of it.
   task automatic send_pixel(input bit [PIX_W-1:0] pix);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      dilate_pixel(pix);
   endtask

   task automatic end_stream();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixels(input bit [PIX_W-1:0] seq[$]);
      foreach (seq[i]) send_pixel(seq[i]);
      end_stream();
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
      end_stream();
   endtask

   // Fill out the current frame so the next pixel starts a new one.
   task automatic complete_frame();
      while (!(col_pos == 0 && row_pos == 0)) send_pixel(random_pixel());
      end_stream();
   endtask

   // Wait for every predicted result, then let in-flight pixels clear.
   task automatic settle();
      while (expected_dilations.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // One register transfer: setup cycle, access cycle, then a bus idle cycle.
   task automatic csr_access(input bit write, input bit [CSR_ADDR_W-1:0] addr,
                             input bit [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic expect_register(input bit [CSR_ADDR_W-1:0] addr, input bit [CFG_W-1:0] want);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, addr, '0, rd);
      if (rd[CFG_W-1:0] !== want) begin
         note_mismatch($sformatf("register at 0x%0h: expected %0d, got %0d",
                                 addr, want, rd[CFG_W-1:0]));
      end
   endtask

   // Writes both size registers while idle. A wider row is only started at a
   // frame boundary, so no result ever draws on an unwritten line entry.
   task automatic set_frame_size(input bit [CFG_W-1:0] w, input bit [CFG_W-1:0] h);
      logic [CSR_DATA_W-1:0] rd;
      if (clamp_size(w, MAX_WIDTH) > clamp_size(size_w, MAX_WIDTH) &&
          !(col_pos == 0 && row_pos == 0)) begin
         complete_frame();
      end
      settle();
      csr_access(1'b1, WIDTH_ADDR, CSR_DATA_W'(w), rd);
      size_w = w;
      csr_access(1'b1, HEIGHT_ADDR, CSR_DATA_W'(h), rd);
      size_h = h;
      expect_register(WIDTH_ADDR, w);
      expect_register(HEIGHT_ADDR, h);
   endtask

   task automatic test_reset_values();
      expect_register(WIDTH_ADDR, 12'd640);
      expect_register(HEIGHT_ADDR, 12'd480);
   endtask

   // Tiny frames with hand-picked pixels: single pixel, zero sizes, a lone
   // peak, one bit per pixel and a single row.
   task automatic test_directed_frames();
      bit [PIX_W-1:0] seq[$];
      set_frame_size(12'd1, 12'd1);
      seq = '{8'd255, 8'd0};
      send_pixels(seq);
      set_frame_size(12'd0, 12'd0);
      seq = '{8'd128, 8'd1};
      send_pixels(seq);
      set_frame_size(12'd3, 12'd3);
      seq = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
      send_pixels(seq);
      set_frame_size(12'd4, 12'd2);
      seq = '{8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128};
      send_pixels(seq);
      set_frame_size(12'd2, 12'd1);
      seq = '{8'd170, 8'd85};
      send_pixels(seq);
   endtask

   // Shrinking the frame mid-way clears a column, then a row, that lies
   // beyond the new size.
   task automatic test_size_change();
      set_frame_size(12'd6, 12'd5);
      send_random(20);
      set_frame_size(12'd2, 12'd5);
      send_random(3);
      set_frame_size(12'd2, 12'd3);
      send_random(2);
      complete_frame();
   endtask

   // Start of the widest row without backpressure, then of the tallest
   // column. Both registers are written above the maximum, which acts as the
   // maximum. A one-pixel frame afterwards keeps the next widening short.
   task automatic test_max_frames();
      set_frame_size(12'd4095, 12'd1);
      steady = 1'b1;
      send_random(MAX_PIX);
      steady = 1'b0;
      set_frame_size(12'd1, 12'd4095);
      send_random(MAX_PIX);
      set_frame_size(12'd1, 12'd1);
   endtask

   // Small random frames, some cut short before the size changes again.
   task automatic test_random_frames();
      int unsigned sent;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      sent = 0;
      while (sent < RANDOM_PIX) begin
         steady = (sent < RANDOM_PIX / 3);
         w = $urandom_range(10, 1);
         h = $urandom_range(6, 1);
         set_frame_size(CFG_W'(w), CFG_W'(h));
         n = ($urandom_range(3) == 0) ? $urandom_range(w * h, 1) : w * h;
         send_random(n);
         sent += n;
      end
      steady = 1'b0;
   endtask

   // Test sequence.
   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_frames();
      test_size_change();
      test_max_frames();
      test_random_frames();
      settle();
      if (mismatch_count == 0) begin
         $display("grayscale_dilate_3x3_top verification clean");
      end else begin
         $display("grayscale_dilate_3x3_top verification failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("grayscale_dilate_3x3_top verification failed");
      $finish;
   end

endmodule
